@@ hw/rtl/sst_pkg.sv @@
// Shared widths and record types for the script source tokenizer.
`default_nettype none

package sst_pkg;

  localparam int WORD_W     = 32;
  localparam int TYPE_W     = 6;
  localparam int CHAR_W     = 8;
  localparam int OUTQ_DEPTH = 4;

  typedef logic [TYPE_W-1:0] tok_type_t;
  typedef logic [WORD_W-1:0] word_t;

  // One token record as it leaves the block.
  typedef struct packed {
    tok_type_t tok_kind;
    word_t     token_line;
    word_t     start_offset;
    word_t     token_length;
    logic      last;
  } rec_t;

  // Which of the two record slots the scanner hands to the output queue.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

`default_nettype wire

@@ hw/rtl/sst_scan.sv @@
// Tokenizer scanner: scan state registers and the per-byte next-state logic.
`default_nettype none

module sst_scan import sst_pkg::*; #(
  parameter int KEYWORD_MAX_LEN = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [CHAR_W-1:0] in_byte,
  input  wire logic              in_eos,
  input  wire logic              cfg_we,
  input  wire logic              cfg_data,
  output push_t                  push,
  output rec_t                   rec0,
  output rec_t                   rec1
);

  localparam int KBUF_W = CHAR_W * KEYWORD_MAX_LEN;
  localparam int NUM_KW = 10;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_COMMENT, MODE_STRING, MODE_NUMBER,
    MODE_IDENT, MODE_PEND_LT, MODE_PEND_GT, MODE_PEND_EQ
  } mode_t;

  typedef enum logic [1:0] {PAIR_NONE, PAIR_CR, PAIR_LF} pair_t;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT     = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_APOS   = 8'h27;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_BAR    = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_TILDE  = 8'h7E;

  // Token type codes.
  localparam tok_type_t TT_LPAREN = 6'd0;
  localparam tok_type_t TT_RPAREN = 6'd1;
  localparam tok_type_t TT_LBRACK = 6'd2;
  localparam tok_type_t TT_RBRACK = 6'd3;
  localparam tok_type_t TT_LBRACE = 6'd4;
  localparam tok_type_t TT_RBRACE = 6'd5;
  localparam tok_type_t TT_TILDE  = 6'd6;
  localparam tok_type_t TT_PLUS   = 6'd7;
  localparam tok_type_t TT_MINUS  = 6'd8;
  localparam tok_type_t TT_STAR   = 6'd9;
  localparam tok_type_t TT_SLASH  = 6'd10;
  localparam tok_type_t TT_LT     = 6'd11;
  localparam tok_type_t TT_LE     = 6'd12;
  localparam tok_type_t TT_GT     = 6'd13;
  localparam tok_type_t TT_GE     = 6'd14;
  localparam tok_type_t TT_ASSIGN = 6'd15;
  localparam tok_type_t TT_EQEQ   = 6'd16;
  localparam tok_type_t TT_DOT    = 6'd17;
  localparam tok_type_t TT_APOS   = 6'd18;
  localparam tok_type_t TT_COMMA  = 6'd19;
  localparam tok_type_t TT_STRING = 6'd20;
  localparam tok_type_t TT_NUMBER = 6'd21;
  localparam tok_type_t TT_IDENT  = 6'd22;
  localparam tok_type_t TT_KW0    = 6'd23;

  // Keywords packed with the first letter in the lowest byte:
  // if continue break while variable with else return create for.
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0000_6669, 64'h6575_6E69_746E_6F63,
    64'h0000_006B_6165_7262, 64'h0000_0065_6C69_6877,
    64'h656C_6261_6972_6176, 64'h0000_0000_6874_6977,
    64'h0000_0000_6573_6C65, 64'h0000_6E72_7574_6572,
    64'h0000_6574_6165_7263, 64'h0000_0000_0072_6F66
  };
  localparam int KW_LEN [NUM_KW] = '{2, 8, 5, 5, 8, 4, 4, 6, 6, 3};

  function automatic word_t sat_inc(input word_t x);
    return (x == '1) ? x : x + word_t'(1);
  endfunction

  mode_t             mode,       mode_next;
  pair_t             pair,       pair_next;
  word_t             byte_pos,   byte_pos_next;
  word_t             line_cnt,   line_cnt_next;
  word_t             open_start, open_start_next;
  word_t             open_len,   open_len_next;
  word_t             open_line,  open_line_next;
  logic [KBUF_W-1:0] kbuf,       kbuf_next;
  logic              first_line;

  rec_t rec_a, rec_b;
  logic a_valid, b_valid;

  always_comb begin
    logic      is_nl, is_ws, is_digit, is_letter;
    logic      single_hit, flush_req, idle_req;
    tok_type_t single_code, kw_type;
    pair_t     me;

    mode_next       = mode;
    pair_next       = pair;
    byte_pos_next   = byte_pos;
    line_cnt_next   = line_cnt;
    open_start_next = open_start;
    open_len_next   = open_len;
    open_line_next  = open_line;
    kbuf_next       = kbuf;

    is_nl     = (in_byte == CH_CR) || (in_byte == CH_LF);
    is_ws     = (in_byte == CH_TAB) || (in_byte == CH_VT) || (in_byte == CH_FF) ||
                (in_byte == CH_SPACE);
    is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    is_letter = ((in_byte >= CH_LO_A) && (in_byte <= CH_LO_Z)) ||
                ((in_byte >= CH_UP_A) && (in_byte <= CH_UP_Z));
    me        = (in_byte == CH_CR) ? PAIR_CR : PAIR_LF;

    single_hit  = 1'b1;
    single_code = TT_LPAREN;
    unique case (in_byte)
      CH_LPAREN: single_code = TT_LPAREN;
      CH_RPAREN: single_code = TT_RPAREN;
      CH_LBRACK: single_code = TT_LBRACK;
      CH_RBRACK: single_code = TT_RBRACK;
      CH_LBRACE: single_code = TT_LBRACE;
      CH_RBRACE: single_code = TT_RBRACE;
      CH_TILDE:  single_code = TT_TILDE;
      CH_PLUS:   single_code = TT_PLUS;
      CH_MINUS:  single_code = TT_MINUS;
      CH_STAR:   single_code = TT_STAR;
      CH_SLASH:  single_code = TT_SLASH;
      CH_DOT:    single_code = TT_DOT;
      CH_APOS:   single_code = TT_APOS;
      CH_COMMA:  single_code = TT_COMMA;
      default:   single_hit  = 1'b0;
    endcase

    // Keyword lookup on the open identifier; at most one entry can match.
    kw_type = TT_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if ((KW_LEN[k] <= KEYWORD_MAX_LEN) && (open_len == word_t'(KW_LEN[k])) &&
          (kbuf == KW_TEXT[k][KBUF_W-1:0])) begin
        kw_type = TT_KW0 + tok_type_t'(k);
      end
    end

    flush_req = 1'b0;
    idle_req  = 1'b0;
    a_valid   = 1'b0;
    rec_a     = '{tok_kind: TT_IDENT, token_line: open_line,
                  start_offset: open_start, token_length: open_len, last: 1'b0};

    if (in_eos) begin
      flush_req     = 1'b1;
      pair_next     = PAIR_NONE;
      byte_pos_next = '0;
      line_cnt_next = word_t'(first_line);
    end else begin
      byte_pos_next = sat_inc(byte_pos);
      unique case (mode)
        MODE_COMMENT: begin
          if (is_nl) begin
            mode_next = MODE_IDLE;
            idle_req  = 1'b1;
          end
        end
        MODE_STRING: begin
          if (in_byte == CH_QUOTE) flush_req = 1'b1;
          else open_len_next = sat_inc(open_len);
        end
        MODE_NUMBER: begin
          if (is_digit || (in_byte == CH_DOT)) begin
            open_len_next = sat_inc(open_len);
          end else begin
            flush_req = 1'b1;
            idle_req  = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_letter || is_digit) begin
            for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
              if (open_len == word_t'(i)) kbuf_next[CHAR_W*i +: CHAR_W] = in_byte;
            end
            open_len_next = sat_inc(open_len);
          end else begin
            flush_req = 1'b1;
            idle_req  = 1'b1;
          end
        end
        MODE_PEND_LT, MODE_PEND_GT, MODE_PEND_EQ: begin
          if (in_byte == CH_EQ) begin
            a_valid                = 1'b1;
            rec_a.token_length     = word_t'(2);
            rec_a.tok_kind         = (mode == MODE_PEND_LT) ? TT_LE :
                                     (mode == MODE_PEND_GT) ? TT_GE : TT_EQEQ;
            mode_next              = MODE_IDLE;
          end else begin
            flush_req = 1'b1;
            idle_req  = 1'b1;
          end
        end
        default: idle_req = 1'b1;
      endcase
    end

    // Close whatever token is open.
    if (flush_req) begin
      mode_next = MODE_IDLE;
      unique case (mode)
        MODE_STRING: begin a_valid = 1'b1; rec_a.tok_kind = TT_STRING; end
        MODE_NUMBER: begin a_valid = 1'b1; rec_a.tok_kind = TT_NUMBER; end
        MODE_IDENT:  begin a_valid = 1'b1; rec_a.tok_kind = kw_type;   end
        MODE_PEND_LT: begin
          a_valid = 1'b1; rec_a.tok_kind = TT_LT; rec_a.token_length = word_t'(1);
        end
        MODE_PEND_GT: begin
          a_valid = 1'b1; rec_a.tok_kind = TT_GT; rec_a.token_length = word_t'(1);
        end
        MODE_PEND_EQ: begin
          a_valid = 1'b1; rec_a.tok_kind = TT_ASSIGN; rec_a.token_length = word_t'(1);
        end
        default: a_valid = 1'b0;
      endcase
    end

    // Handle the byte as if no token were open.
    b_valid = 1'b0;
    rec_b   = '{tok_kind: single_code, token_line: line_cnt,
                start_offset: byte_pos, token_length: word_t'(1), last: 1'b1};
    if (idle_req) begin
      if (is_nl) begin
        if ((pair != PAIR_NONE) && (pair != me)) begin
          pair_next = PAIR_NONE;
        end else begin
          line_cnt_next = sat_inc(line_cnt);
          pair_next     = me;
        end
      end else begin
        pair_next = PAIR_NONE;
        priority if (is_ws) begin
          mode_next = MODE_IDLE;
        end else if (in_byte == CH_BAR) begin
          mode_next = MODE_COMMENT;
        end else if (single_hit) begin
          b_valid = 1'b1;
        end else if ((in_byte == CH_LT) || (in_byte == CH_GT) || (in_byte == CH_EQ) ||
                     is_digit || is_letter) begin
          mode_next       = (in_byte == CH_LT) ? MODE_PEND_LT :
                            (in_byte == CH_GT) ? MODE_PEND_GT :
                            (in_byte == CH_EQ) ? MODE_PEND_EQ :
                            is_digit           ? MODE_NUMBER  : MODE_IDENT;
          open_start_next = byte_pos;
          open_len_next   = word_t'(1);
          open_line_next  = line_cnt;
          kbuf_next       = KBUF_W'(in_byte);
        end else if (in_byte == CH_QUOTE) begin
          mode_next       = MODE_STRING;
          open_start_next = sat_inc(byte_pos);
          open_len_next   = '0;
          open_line_next  = line_cnt;
        end else begin
          mode_next = MODE_IDLE;
        end
      end
    end
  end

  // Pack the two possible records into the lowest slots.
  always_comb begin
    rec0        = a_valid ? rec_a : rec_b;
    rec0.last   = !(a_valid && b_valid);
    rec1        = rec_b;
    push.first  = step && (a_valid || b_valid);
    push.second = step && a_valid && b_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      pair       <= PAIR_NONE;
      byte_pos   <= '0;
      line_cnt   <= word_t'(1);
      open_start <= '0;
      open_len   <= '0;
      open_line  <= '0;
      kbuf       <= '0;
      first_line <= 1'b1;
    end else begin
      if (cfg_we) first_line <= cfg_data;
      if (step) begin
        mode       <= mode_next;
        pair       <= pair_next;
        byte_pos   <= byte_pos_next;
        line_cnt   <= line_cnt_next;
        open_start <= open_start_next;
        open_len   <= open_len_next;
        open_line  <= open_line_next;
        kbuf       <= kbuf_next;
      end else if (cfg_we && (byte_pos == '0) && (mode == MODE_IDLE)) begin
        line_cnt <= word_t'(cfg_data);
      end
    end
  end

  a_eos_restarts: assert property (@(posedge clk) disable iff (rst)
    (step && in_eos) |=> (byte_pos == '0) && (mode == MODE_IDLE) && (pair == PAIR_NONE))
    else $error("end of source did not restart the scanner");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("second record pushed without a first");

  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    (step && !in_eos && (byte_pos == '1)) |=> (byte_pos == '1))
    else $error("byte position wrapped");

endmodule

`default_nettype wire

@@ hw/rtl/sst_outq.sv @@
// Tokenizer output queue: small record FIFO that takes up to two records a cycle.
`default_nettype none

module sst_outq import sst_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  input  wire rec_t  rec0,
  input  wire rec_t  rec1,
  output logic       space_ok,
  output logic       out_valid,
  input  wire logic  out_ready,
  output rec_t       out_rec
);

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  rec_t             q [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  assign out_valid = (count != '0);
  assign out_rec   = q[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Room for the worst case of two records from one word.
  assign space_ok  = (count <= CNT_W'(OUTQ_DEPTH - 2));

  assign count_next = count + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.first)  q[wr_ptr] <= rec0;
    if (push.second) q[wr_ptr + PTR_W'(1)] <= rec1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.first) + PTR_W'(push.second);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(OUTQ_DEPTH))
    else $error("output queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.first |-> (count <= CNT_W'(OUTQ_DEPTH - 2)))
    else $error("records pushed without room for two");

  a_pop_only_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push.first) |=> (count == $past(count) - CNT_W'(1)))
    else $error("queue count wrong after a pop");

endmodule

`default_nettype wire

@@ hw/rtl/script_source_tokenizer.sv @@
// Top level of the script source tokenizer: input register, scanner and output queue.
//
// The tokenizer takes one source byte per word on the slave stream (tlast marks
// the end-of-source word, which carries no byte) and delivers one token record per
// word on the master stream. A word is registered, decoded combinationally against
// the scan state, and its records land in a four-entry output queue, so a new
// word is accepted every cycle as long as the queue has room for two records. Most
// words yield zero or one token; a word that both closes an open token and starts
// a one-character token yields two, and the master side then needs a word for each
// of them, which is what limits the sustained rate on such input to one word per
// token delivered. A word waits in the input register and its records in the output
// queue before the master side. The tlast flag on the master side marks the final record
// caused by one input word. The one configuration bit gives the number of the first
// source line; writing it before any byte of a source also reloads the line counter.
// Line numbers, offsets and lengths saturate at all ones. Identifiers of at most
// KEYWORD_MAX_LEN letters are checked against the ten keywords.
`default_nettype none

module script_source_tokenizer import sst_pkg::*; #(
  parameter int KEYWORD_MAX_LEN = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // Slave stream.
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,   // [7:0] char_byte
  input  wire logic          s_axis_tlast,   // end_of_source
  // Master stream.
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [95:0]        m_axis_tdata,   // [31:0] token_line, [63:32] start_offset,
                                             // [95:64] token_length
  output logic [5:0]         m_axis_tuser,   // [5:0] token kind
  output logic               m_axis_tlast,   // last
  // Configuration.
  input  wire logic          cfg_we,
  input  wire logic          cfg_data        // first_line_number
);

  logic              in_valid;
  logic [CHAR_W-1:0] in_byte;
  logic              in_eos;
  logic              space_ok;
  logic              step;
  push_t             push;
  rec_t              rec0, rec1, out_rec;

  // The registered word is scanned when the output queue can take both records.
  assign step          = in_valid && space_ok;
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  // Word payload needs no reset.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_eos  <= s_axis_tlast;
    end
  end

  sst_scan #(
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .in_byte  (in_byte),
    .in_eos   (in_eos),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .rec0     (rec0),
    .rec1     (rec1)
  );

  sst_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rec0      (rec0),
    .rec1      (rec1),
    .space_ok  (space_ok),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rec   (out_rec)
  );

  assign m_axis_tdata = {out_rec.token_length, out_rec.start_offset, out_rec.token_line};
  assign m_axis_tuser = out_rec.tok_kind;
  assign m_axis_tlast = out_rec.last;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the script source tokenizer on its stream ports.
module testbench;
  import sst_pkg::*;

  localparam int KW_MAX_LEN      = 8;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int PHASES          = 5;
  localparam int WORDS_PER_PHASE = 250;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Token codes as they appear on tuser, in the order the block numbers them.
  typedef enum logic [5:0] {
    T_LPAREN, T_RPAREN, T_LBRACK, T_RBRACK, T_LBRACE, T_RBRACE, T_TILDE,
    T_PLUS, T_MINUS, T_STAR, T_SLASH, T_LT, T_LE, T_GT, T_GE, T_ASSIGN,
    T_EQ, T_DOT, T_QUOTE, T_COMMA, T_STRING, T_NUMBER, T_IDENT,
    T_KW_IF, T_KW_CONTINUE, T_KW_BREAK, T_KW_WHILE, T_KW_VARIABLE,
    T_KW_WITH, T_KW_ELSE, T_KW_RETURN, T_KW_CREATE, T_KW_FOR
  } tok_kind_t;

  // What the scanner is in the middle of between two source words.
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_COMMENT, SCAN_STRING, SCAN_NUMBER, SCAN_IDENT,
    SCAN_PEND_LT, SCAN_PEND_GT, SCAN_PEND_EQ
  } scan_t;

  // Line-end byte that may still pair with the next one into a single line end.
  typedef enum logic [1:0] {NL_NONE, NL_CR, NL_LF} nl_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } src_word_t;

  typedef struct packed {
    tok_kind_t kind;
    word_t     line;
    word_t     start;
    word_t     len;
    logic      last;
  } token_rec_t;

  // Clock, reset and every block input start at known values.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [5:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_data = 1'b1;

  always #6 clk = ~clk;

  script_source_tokenizer #(.KEYWORD_MAX_LEN(KW_MAX_LEN)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data)
  );

  // Source words waiting for the driver, and token records the block still owes us.
  src_word_t  source_q[$];
  token_rec_t pending_tokens[$];
  token_rec_t step_tokens[$];

  // Private copy of the scanner state.
  scan_t       scan;
  nl_t         nl_open;
  word_t       pos;
  word_t       line_no;
  word_t       tok_start;
  word_t       tok_len;
  word_t       tok_line;
  logic [63:0] kw_buf;
  logic        first_line;

  // Handshake bookkeeping shared between the edge-triggered processes.
  bit in_taken, out_taken;
  bit in_calm, out_calm;
  int in_wait, out_wait;
  int quiet_cycles;
  int mismatches;
  int words_taken, eos_taken, tokens_checked, cfg_writes, words_queued;

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  // Offsets, lengths and the line counter stop at all ones instead of wrapping.
  function automatic word_t sat_inc(word_t x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_eol(logic [7:0] c);
    return c == CH_CR || c == CH_LF;
  endfunction

  function automatic string kw_word(int k);
    case (k)
      0: return "if";
      1: return "continue";
      2: return "break";
      3: return "while";
      4: return "variable";
      5: return "with";
      6: return "else";
      7: return "return";
      8: return "create";
      default: return "for";
    endcase
  endfunction

  // One-character tokens that never wait for a following byte.
  function automatic bit single_kind(logic [7:0] c, output tok_kind_t k);
    single_kind = 1'b1;
    k = T_LPAREN;
    case (c)
      "(":  k = T_LPAREN;
      ")":  k = T_RPAREN;
      "[":  k = T_LBRACK;
      "]":  k = T_RBRACK;
      "{":  k = T_LBRACE;
      "}":  k = T_RBRACE;
      "~":  k = T_TILDE;
      "+":  k = T_PLUS;
      "-":  k = T_MINUS;
      "*":  k = T_STAR;
      "/":  k = T_SLASH;
      ".":  k = T_DOT;
      "'":  k = T_QUOTE;
      ",":  k = T_COMMA;
      default: single_kind = 1'b0;
    endcase
  endfunction

  // An identifier is a keyword only when its length and its packed letters both match;
  // anything longer than the keyword buffer is a plain identifier.
  function automatic tok_kind_t ident_kind();
    logic [63:0] packed_kw;
    string       s;
    if (tok_len > KW_MAX_LEN) return T_IDENT;
    for (int k = 0; k < 10; k++) begin
      s = kw_word(k);
      if (s.len() == tok_len) begin
        packed_kw = '0;
        for (int i = 0; i < s.len(); i++) packed_kw[8*i +: 8] = s[i];
        if (packed_kw == kw_buf) return tok_kind_t'(T_KW_IF + k);
      end
    end
    return T_IDENT;
  endfunction

  function automatic void emit_token(tok_kind_t k, word_t ln, word_t st, word_t len);
    token_rec_t r;
    r.kind  = k;
    r.line  = ln;
    r.start = st;
    r.len   = len;
    r.last  = 1'b0;
    step_tokens.push_back(r);
  endfunction

  // Closes whatever token is open; a comment closes silently.
  function automatic void close_token();
    case (scan)
      SCAN_STRING:  emit_token(T_STRING, tok_line, tok_start, tok_len);
      SCAN_NUMBER:  emit_token(T_NUMBER, tok_line, tok_start, tok_len);
      SCAN_IDENT:   emit_token(ident_kind(), tok_line, tok_start, tok_len);
      SCAN_PEND_LT: emit_token(T_LT, tok_line, tok_start, 1);
      SCAN_PEND_GT: emit_token(T_GT, tok_line, tok_start, 1);
      SCAN_PEND_EQ: emit_token(T_ASSIGN, tok_line, tok_start, 1);
      default: ;
    endcase
    scan = SCAN_IDLE;
  endfunction

  function automatic void open_token(scan_t mode, word_t st, word_t len);
    scan      = mode;
    tok_start = st;
    tok_len   = len;
    tok_line  = line_no;
  endfunction

  // A byte seen with nothing open. Whitespace and the discarded punctuation match
  // none of the branches below and only clear a pending line-end pair.
  function automatic void idle_byte(logic [7:0] c, word_t p);
    tok_kind_t k;
    nl_t       me;
    if (is_eol(c)) begin
      me = (c == CH_CR) ? NL_CR : NL_LF;
      // CR LF and LF CR count once; CR CR or LF LF are two line ends.
      if (nl_open != NL_NONE && nl_open != me) begin
        nl_open = NL_NONE;
      end else begin
        line_no = sat_inc(line_no);
        nl_open = me;
      end
    end else begin
      nl_open = NL_NONE;
      if (c == "|") begin
        scan = SCAN_COMMENT;
      end else if (single_kind(c, k)) begin
        emit_token(k, line_no, p, 1);
      end else if (c == "<") begin
        open_token(SCAN_PEND_LT, p, 1);
      end else if (c == ">") begin
        open_token(SCAN_PEND_GT, p, 1);
      end else if (c == "=") begin
        open_token(SCAN_PEND_EQ, p, 1);
      end else if (c == "\"") begin
        // String text starts after the opening quote.
        open_token(SCAN_STRING, sat_inc(p), 0);
      end else if (is_digit(c)) begin
        open_token(SCAN_NUMBER, p, 1);
      end else if (is_letter(c)) begin
        open_token(SCAN_IDENT, p, 1);
        kw_buf = {56'd0, c};
      end
    end
  endfunction

  function automatic void take_byte(logic [7:0] c, word_t p);
    bit reissue;
    reissue = 1'b0;
    case (scan)
      SCAN_IDLE: idle_byte(c, p);
      SCAN_COMMENT: begin
        if (is_eol(c)) begin
          scan = SCAN_IDLE;
          idle_byte(c, p);
        end
      end
      // Line ends inside a string are text and do not move the line counter.
      SCAN_STRING: begin
        if (c == "\"") close_token();
        else tok_len = sat_inc(tok_len);
      end
      SCAN_NUMBER: begin
        if (is_digit(c) || c == ".") tok_len = sat_inc(tok_len);
        else reissue = 1'b1;
      end
      SCAN_IDENT: begin
        if (is_letter(c) || is_digit(c)) begin
          if (tok_len < KW_MAX_LEN) kw_buf[8*tok_len[2:0] +: 8] = c;
          tok_len = sat_inc(tok_len);
        end else begin
          reissue = 1'b1;
        end
      end
      default: begin
        // A pending <, > or = either pairs with '=' or is closed on its own.
        if (c == "=") begin
          emit_token(scan == SCAN_PEND_LT ? T_LE : scan == SCAN_PEND_GT ? T_GE : T_EQ,
                     tok_line, tok_start, 2);
          scan = SCAN_IDLE;
        end else begin
          reissue = 1'b1;
        end
      end
    endcase
    // The byte that closed a token is then handled as if nothing were open,
    // which is how a number followed by a letter becomes two tokens.
    if (reissue) begin
      close_token();
      idle_byte(c, p);
    end
  endfunction

  // Works out the records caused by one accepted source word and queues them.
  function automatic void tokenize_word(logic [7:0] c, logic eos);
    step_tokens.delete();
    if (eos) begin
      close_token();
      nl_open = NL_NONE;
      pos     = '0;
      line_no = {31'd0, first_line};
    end else begin
      take_byte(c, pos);
      pos = sat_inc(pos);
    end
    if (step_tokens.size() != 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
  endfunction

  function automatic void scanner_reset();
    first_line = 1'b1;
    scan       = SCAN_IDLE;
    nl_open    = NL_NONE;
    pos        = '0;
    line_no    = 32'd1;
    tok_start  = '0;
    tok_len    = '0;
    tok_line   = '0;
    kw_buf     = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("testbench: mismatch: %s", msg);
  endfunction

  function automatic void check_token();
    token_rec_t want;
    if (pending_tokens.size() == 0) begin
      note_mismatch($sformatf("token with nothing expected: type %0d line %0d start %0d len %0d",
                              m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                              m_axis_tdata[95:64]));
    end else begin
      want = pending_tokens.pop_front();
      tokens_checked++;
      if (m_axis_tuser !== want.kind || m_axis_tdata[31:0] !== want.line ||
          m_axis_tdata[63:32] !== want.start || m_axis_tdata[95:64] !== want.len ||
          m_axis_tlast !== want.last) begin
        note_mismatch($sformatf(
          "token %0d expected type %0d line %0d start %0d len %0d last %0b, got %0d %0d %0d %0d %0b",
          tokens_checked, want.kind, want.line, want.start, want.len, want.last,
          m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
          m_axis_tlast));
      end
    end
  endfunction

  // Everything that happens on a rising edge: the monitor checks a delivered token,
  // the predictor takes an accepted source word, and the watchdog counts quiet cycles.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_token();
        out_taken = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tokenize_word(s_axis_tdata, s_axis_tlast);
        in_taken = 1'b1;
        words_taken++;
        if (s_axis_tlast) eos_taken++;
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("testbench: timeout after %0d cycles without a handshake", WATCHDOG_LIMIT);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and output back-pressure
  // ---------------------------------------------------------------------------

  // Draws a per-word wait at random, with calm stretches where nothing waits at all.
  function automatic int idle_len(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // The driver holds a word until it is taken, then waits its drawn gap before the next.
  always @(negedge clk) begin
    src_word_t w;
    if (!rst && (in_taken || !s_axis_tvalid)) begin
      in_taken = 1'b0;
      if (in_wait != 0) begin
        in_wait = in_wait - 1;
        s_axis_tvalid <= 1'b0;
      end else if (source_q.size() != 0) begin
        w = source_q.pop_front();
        s_axis_tdata  <= w.ch;
        s_axis_tlast  <= w.eos;
        s_axis_tvalid <= 1'b1;
        in_wait = idle_len(in_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // After each delivered token the receiver stalls for a freshly drawn number of cycles.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_wait  = idle_len(out_calm);
      end
      if (out_wait != 0) begin
        out_wait = out_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void add_byte(logic [7:0] b);
    src_word_t w;
    w.ch  = b;
    w.eos = 1'b0;
    source_q.push_back(w);
    words_queued++;
  endfunction

  // The byte lane of an end marker is don't-care, so it carries random bits.
  function automatic void add_eos();
    src_word_t w;
    w.ch  = 8'($urandom_range(0, 255));
    w.eos = 1'b1;
    source_q.push_back(w);
    words_queued++;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return $urandom_range(0, 3) == 0 ? 8'("0" + $urandom_range(0, 9)) : rand_letter();
  endfunction

  function automatic logic [7:0] rand_eol();
    return $urandom_range(0, 1) ? CH_CR : CH_LF;
  endfunction

  // Appends one well-formed lexeme with random content, or now and then noise or an
  // end marker. Lexemes run together without spaces most of the time, so the
  // boundaries between them exercise the reissue paths.
  function automatic void add_random_lexeme();
    int          pick, n;
    string       s;
    logic [7:0]  b;
    string       ops;
    string       dropped;
    ops     = "()[]{}~+-*/.',<>=";
    dropped = ":_#;&!";
    pick    = $urandom_range(0, 99);
    if (pick < 12) begin
      n = $urandom_range(1, 12);
      add_byte(rand_letter());
      for (int i = 1; i < n; i++) add_byte(rand_alnum());
    end else if (pick < 24) begin
      // Keywords, sometimes capitalized or stretched past a keyword's length.
      s = kw_word($urandom_range(0, 9));
      n = $urandom_range(0, 9);
      for (int i = 0; i < s.len(); i++) begin
        b = s[i];
        if (i == 0 && n == 0) b = b - 8'd32;
        add_byte(b);
      end
      if (n < 3) add_byte(rand_alnum());
    end else if (pick < 32) begin
      add_byte(8'("0" + $urandom_range(0, 9)));
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++)
        add_byte($urandom_range(0, 3) == 0 ? 8'(".") : 8'("0" + $urandom_range(0, 9)));
    end else if (pick < 40) begin
      add_byte("\"");
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        b = $urandom_range(0, 3) == 0 ? rand_eol() : 8'($urandom_range(0, 255));
        add_byte(b == "\"" ? 8'("x") : b);
      end
      if ($urandom_range(0, 9) != 0) add_byte("\"");
    end else if (pick < 60) begin
      b = ops[$urandom_range(0, ops.len() - 1)];
      add_byte(b);
      if ((b == "<" || b == ">" || b == "=") && $urandom_range(0, 1)) add_byte("=");
    end else if (pick < 70) begin
      case ($urandom_range(0, 3))
        0: add_byte(" ");
        1: add_byte(CH_TAB);
        2: add_byte(CH_VT);
        default: add_byte(CH_FF);
      endcase
    end else if (pick < 78) begin
      // Single line ends and the CR LF, LF CR, CR CR and LF LF pairs.
      add_byte(rand_eol());
      if ($urandom_range(0, 1)) add_byte(rand_eol());
    end else if (pick < 84) begin
      add_byte("|");
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(0, 255));
        add_byte(is_eol(b) ? 8'("c") : b);
      end
      add_byte(rand_eol());
    end else if (pick < 90) begin
      add_byte(dropped[$urandom_range(0, dropped.len() - 1)]);
    end else if (pick < 98) begin
      add_byte(8'($urandom_range(0, 255)));
    end else begin
      add_eos();
    end
  endfunction

  // Lets all queued words go in and all owed tokens come out, then allows for words
  // that were accepted but cause no token and may still be in the pipeline.
  task automatic wait_drained();
    while (source_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The register reloads the line counter only before the first byte of a source.
  task automatic set_first_line(logic v);
    @(negedge clk);
    cfg_data <= v;
    cfg_we   <= 1'b1;
    @(negedge clk);
    cfg_we   <= 1'b0;
    first_line = v;
    if (pos == '0 && scan == SCAN_IDLE) line_no = {31'd0, v};
    cfg_writes++;
  endtask

  initial begin : stimulus
    int start;
    scanner_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening: number then letter, all three two-byte operators, a
    // one-character token, a line end inside a string, both byte extremes, a CR LF
    // pair then a lone LF, a comment cut off by the end of source, and an
    // unterminated string at the end of source.
    add_text("9a<=>===(");
    add_byte("\"");
    add_byte(CH_CR);
    add_byte("\"");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_CR);
    add_byte(CH_LF);
    add_byte(CH_LF);
    add_text("if|c");
    add_eos();
    add_text("\"q");
    add_eos();

    // Random phases with a register write before each. Even phases end the source,
    // so the next write reloads the line counter; odd ones leave it mid-source.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      set_first_line(phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
      start = words_queued;
      while (words_queued - start < WORDS_PER_PHASE) add_random_lexeme();
      if (phase % 2 == 0) add_eos();
    end
    wait_drained();

    $display("testbench: %0d source words taken, %0d of them end markers, %0d register writes",
             words_taken, eos_taken, cfg_writes);
    $display("testbench: %0d tokens checked, %0d mismatches, %0d tokens still owed",
             tokens_checked, mismatches, pending_tokens.size());
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
